>>> src/gpmx_pkg.sv
// shared types and constants for the generalized partially mapped crossover block
// no dependencies; used by gpmx_ctrl, gpmx_dpath and permutation_gpmx_crossover
`default_nettype none
package gpmx_pkg;

	localparam int GENE_W    = 6;
	localparam int GENE_VALS = 64;
	localparam int CFG_W     = 7;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
	localparam logic [CFG_W-1:0] MIN_GENES = 7'd2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_START = 1'b1;

	typedef struct packed {
		logic load;
		logic init;
		logic err;
		logic mark_en;
		logic comp_en;
		logic emit_en;
		logic step_clr;
	} cmd_t;

	typedef struct packed {
		logic req_bad;
		logic step_last;
		logic pipe_busy;
	} status_t;

endpackage
`default_nettype wire

>>> src/gpmx_ctrl.sv
// phase sequencer for the crossover: mark, compact, emit
// depends on gpmx_pkg (cmd_t, status_t, command codes)
`default_nettype none
module gpmx_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic              command,
	input  wire gpmx_pkg::status_t st,
	output gpmx_pkg::cmd_t         cmd,
	output logic                   active
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MARK = 3'd1;
	localparam logic [2:0] S_COMP = 3'd2;
	localparam logic [2:0] S_GAP  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && command == gpmx_pkg::CMD_LOAD) begin
					cmd.load = 1'b1;
				end else if (accept && command == gpmx_pkg::CMD_START) begin
					if (st.req_bad) begin
						cmd.err = 1'b1;
					end else begin
						cmd.init = 1'b1;
						state_d  = S_MARK;
					end
				end
			end
			S_MARK: begin
				cmd.mark_en = 1'b1;
				if (st.step_last) begin
					cmd.step_clr = 1'b1;
					state_d      = S_COMP;
				end
			end
			S_COMP: begin
				cmd.comp_en = 1'b1;
				if (st.step_last) begin
					cmd.step_clr = 1'b1;
					state_d      = S_GAP;
				end
			end
			// lets the last queue write land before the first queue read
			S_GAP: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit_en = 1'b1;
				if (st.step_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign active = (state_q != S_IDLE);

endmodule
`default_nettype wire

>>> src/gpmx_dpath.sv
// datapath: parent memories, segment marks, donor queues and result register
// depends on gpmx_pkg; driven by gpmx_ctrl through cmd_t / status_t
`default_nettype none
module gpmx_dpath #(
	parameter int MAX_GENES = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire gpmx_pkg::cmd_t               cmd,
	output gpmx_pkg::status_t                 st,
	input  wire logic [5:0]                   gene_index,
	input  wire logic [gpmx_pkg::GENE_W-1:0]  gene_a,
	input  wire logic [gpmx_pkg::GENE_W-1:0]  gene_b,
	input  wire logic [5:0]                   cut_start,
	input  wire logic [5:0]                   cut_length,
	input  wire logic                         gene_count_we,
	input  wire logic [gpmx_pkg::CFG_W-1:0]   gene_count_wdata,
	output logic                              strobe,
	output logic [5:0]                        out_index,
	output logic [gpmx_pkg::GENE_W-1:0]       child_a_gene,
	output logic [gpmx_pkg::GENE_W-1:0]       child_b_gene,
	output logic                              last_gene,
	output logic                              bad_request
);

	localparam int AW    = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1;
	localparam int CW    = $clog2(MAX_GENES + 1);
	localparam int DW    = CW + 1;
	localparam int GW    = gpmx_pkg::GENE_W;
	localparam int CFG_W = gpmx_pkg::CFG_W;
	localparam int NV    = gpmx_pkg::GENE_VALS;

	// configuration
	logic [CFG_W-1:0] gene_count_q;
	logic [CFG_W-1:0] eff_count;

	// job parameters
	logic [CW-1:0] n_q;
	logic [AW-1:0] start_q;
	logic [AW-1:0] len_q;

	// sequencing
	logic [CW-1:0] step_q;
	logic [AW-1:0] wrap_q;
	logic [AW-1:0] rd_addr;

	// memories
	logic [GW-1:0] mem_a [MAX_GENES];
	logic [GW-1:0] mem_b [MAX_GENES];
	logic [GW-1:0] qa_mem [MAX_GENES];
	logic [GW-1:0] qb_mem [MAX_GENES];
	logic [GW-1:0] rd_a_q;
	logic [GW-1:0] rd_b_q;
	logic [GW-1:0] qa_data_q;
	logic [GW-1:0] qb_data_q;

	logic [NV-1:0] mark_a_q;
	logic [NV-1:0] mark_b_q;

	logic [CW-1:0] qa_wr_q, qb_wr_q, qa_rd_q, qb_rd_q;

	// stage 1 of each phase (memory data valid)
	logic          mark_v_s1, comp_v_s1, emit_v_s1;
	logic          seg_s1, avail_a_s1, avail_b_s1, last_s1;
	logic [CW-1:0] pos_s1;

	logic          load_ok;
	logic          last_now;
	logic [DW-1:0] pe, se, ne, seg_ofs;
	logic          seg_now, avail_a_now, avail_b_now;
	logic          keep_b, keep_a;

	// effective count saturated into the legal range
	always_comb begin
		if (gene_count_q < gpmx_pkg::MIN_GENES) begin
			eff_count = gpmx_pkg::MIN_GENES;
		end else if (gene_count_q > CFG_W'(MAX_GENES)) begin
			eff_count = CFG_W'(MAX_GENES);
		end else begin
			eff_count = gene_count_q;
		end
	end

	assign st.req_bad = ({1'b0, cut_start} >= eff_count) || (cut_length == '0)
		|| ({1'b0, cut_length} >= eff_count);

	assign last_now = cmd.mark_en ? (step_q == CW'(len_q) - CW'(1))
		: (step_q == n_q - CW'(1));
	assign st.step_last = last_now;
	assign st.pipe_busy = mark_v_s1 | comp_v_s1 | emit_v_s1;

	assign load_ok = cmd.load && ({1'b0, gene_index} < CFG_W'(MAX_GENES));
	assign rd_addr = cmd.mark_en ? wrap_q : step_q[AW-1:0];

	// circular segment test for the current position
	assign pe      = DW'(step_q);
	assign se      = DW'(start_q);
	assign ne      = DW'(n_q);
	assign seg_ofs = (pe >= se) ? (pe - se) : (pe + ne - se);
	assign seg_now     = seg_ofs < DW'(len_q);
	assign avail_a_now = qa_rd_q < qa_wr_q;
	assign avail_b_now = qb_rd_q < qb_wr_q;

	// donor genes not marked by the other parent's segment
	assign keep_b = !mark_a_q[rd_b_q];
	assign keep_a = !mark_b_q[rd_a_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gene_count_q <= gpmx_pkg::CFG_RESET;
		end else if (gene_count_we) begin
			gene_count_q <= gene_count_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			n_q     <= eff_count[CW-1:0];
			start_q <= cut_start[AW-1:0];
			len_q   <= cut_length[AW-1:0];
		end
	end

	// parent memories
	always_ff @(posedge clk) begin
		if (load_ok) begin
			mem_a[gene_index[AW-1:0]] <= gene_a;
			mem_b[gene_index[AW-1:0]] <= gene_b;
		end
		rd_a_q <= mem_a[rd_addr];
		rd_b_q <= mem_b[rd_addr];
	end

	// donor queues
	always_ff @(posedge clk) begin
		if (comp_v_s1 && keep_b) begin
			qa_mem[qa_wr_q[AW-1:0]] <= rd_b_q;
		end
		if (comp_v_s1 && keep_a) begin
			qb_mem[qb_wr_q[AW-1:0]] <= rd_a_q;
		end
		qa_data_q <= qa_mem[qa_rd_q[AW-1:0]];
		qb_data_q <= qb_mem[qb_rd_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= '0;
			wrap_q    <= '0;
			mark_a_q  <= '0;
			mark_b_q  <= '0;
			qa_wr_q   <= '0;
			qb_wr_q   <= '0;
			qa_rd_q   <= '0;
			qb_rd_q   <= '0;
			mark_v_s1 <= 1'b0;
			comp_v_s1 <= 1'b0;
			emit_v_s1 <= 1'b0;
		end else begin
			mark_v_s1 <= cmd.mark_en;
			comp_v_s1 <= cmd.comp_en;
			emit_v_s1 <= cmd.emit_en;

			if (cmd.init || cmd.step_clr) begin
				step_q <= '0;
			end else if (cmd.mark_en || cmd.comp_en || cmd.emit_en) begin
				step_q <= step_q + CW'(1);
			end

			if (cmd.init) begin
				wrap_q <= cut_start[AW-1:0];
			end else if (cmd.mark_en) begin
				wrap_q <= (CW'(wrap_q) == n_q - CW'(1)) ? '0 : wrap_q + AW'(1);
			end

			if (cmd.init) begin
				mark_a_q <= '0;
				mark_b_q <= '0;
			end else if (mark_v_s1) begin
				mark_a_q[rd_a_q] <= 1'b1;
				mark_b_q[rd_b_q] <= 1'b1;
			end

			if (cmd.init) begin
				qa_wr_q <= '0;
				qb_wr_q <= '0;
				qa_rd_q <= '0;
				qb_rd_q <= '0;
			end else begin
				if (comp_v_s1 && keep_b) begin
					qa_wr_q <= qa_wr_q + CW'(1);
				end
				if (comp_v_s1 && keep_a) begin
					qb_wr_q <= qb_wr_q + CW'(1);
				end
				if (cmd.emit_en && !seg_now && avail_a_now) begin
					qa_rd_q <= qa_rd_q + CW'(1);
				end
				if (cmd.emit_en && !seg_now && avail_b_now) begin
					qb_rd_q <= qb_rd_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		seg_s1     <= seg_now;
		avail_a_s1 <= avail_a_now;
		avail_b_s1 <= avail_b_now;
		last_s1    <= last_now;
		pos_s1     <= step_q;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= emit_v_s1 | cmd.err;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.err) begin
			out_index    <= '0;
			child_a_gene <= '0;
			child_b_gene <= '0;
			last_gene    <= 1'b1;
			bad_request  <= 1'b1;
		end else if (emit_v_s1) begin
			out_index    <= 6'(pos_s1);
			child_a_gene <= seg_s1 ? rd_a_q : (avail_a_s1 ? qa_data_q : '0);
			child_b_gene <= seg_s1 ? rd_b_q : (avail_b_s1 ? qb_data_q : '0);
			last_gene    <= last_s1;
			bad_request  <= 1'b0;
		end
	end

endmodule
`default_nettype wire

>>> src/permutation_gpmx_crossover.sv
// a load gives no beat; a bad start gives its error beat in the cycle after acceptance;
//   a good start gives its beats after the mark and compact phases and holds busy until
//   the sequencer is idle and the pipe drained; only then is the next command taken
//   (one read a cycle in mark, compact, emit); the receiver cannot stall, one beat per cycle
// reset: arst_n clears sequencer, marks and gene_count (to 64); parent stores are not cleared
// depends on gpmx_pkg, gpmx_ctrl, gpmx_dpath
`default_nettype none
module permutation_gpmx_crossover #(
	parameter int MAX_GENES = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// command side
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         command,
	input  wire logic [5:0]                   gene_index,
	input  wire logic [gpmx_pkg::GENE_W-1:0]  gene_a,
	input  wire logic [gpmx_pkg::GENE_W-1:0]  gene_b,
	input  wire logic [5:0]                   cut_start,
	input  wire logic [5:0]                   cut_length,
	// configuration
	input  wire logic                         gene_count_we,
	input  wire logic [gpmx_pkg::CFG_W-1:0]   gene_count_wdata,
	// result side
	output logic                              strobe,
	output logic [5:0]                        out_index,
	output logic [gpmx_pkg::GENE_W-1:0]       child_a_gene,
	output logic [gpmx_pkg::GENE_W-1:0]       child_b_gene,
	output logic                              last_gene,
	output logic                              bad_request
);

	gpmx_pkg::cmd_t    cmd;
	gpmx_pkg::status_t st;
	logic              accept;
	logic              active;

	// a command is taken only with the sequencer idle and the pipe drained
	assign accept = start && !busy;
	assign busy   = active || st.pipe_busy;

	// sequencer: idle -> mark (len steps) -> compact (n steps) -> gap -> emit (n steps)
	gpmx_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.command (command),
		.st      (st),
		.cmd     (cmd),
		.active  (active)
	);

	// mark phase flags the segment genes of each parent, compact phase queues the
	// unmarked donor genes in donor order, emit phase merges segment and queue
	gpmx_dpath #(
		.MAX_GENES (MAX_GENES)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.gene_index       (gene_index),
		.gene_a           (gene_a),
		.gene_b           (gene_b),
		.cut_start        (cut_start),
		.cut_length       (cut_length),
		.gene_count_we    (gene_count_we),
		.gene_count_wdata (gene_count_wdata),
		.strobe           (strobe),
		.out_index        (out_index),
		.child_a_gene     (child_a_gene),
		.child_b_gene     (child_b_gene),
		.last_gene        (last_gene),
		.bad_request      (bad_request)
	);

	// an error beat is always the final beat
	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && bad_request |-> last_gene)
		else $error("error beat without last flag");

	// a rejected start answers in the very next cycle
	a_bad_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept && command == gpmx_pkg::CMD_START && st.req_bad |=> strobe && bad_request)
		else $error("bad start gave no error beat");

	// a load produces no beat
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept && command == gpmx_pkg::CMD_LOAD |=> !strobe)
		else $error("beat after a load");

	// a good start keeps the block busy
	a_good_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init |=> busy)
		else $error("sequencer idle after good start");

endmodule
`default_nettype wire
